### design/pcc_pkg.sv
package pcc_pkg;

    localparam logic [7:0] ESC_CHAR  = 8'd27;
    localparam logic [7:0] PIPE_CHAR = 8'h7C;

    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

    // one queued job: either ESC plus optional colour suffix, or up to three literal bytes
    typedef struct packed {
        logic            esc;
        logic [3:0]      num;
        logic [1:0]      nlit;
        logic [2:0][7:0] lit;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

### design/pipe_color_code_to_ansi.sv
// Pipe colour code to terminal escape translator. One text byte enters per cycle
// while the queue is not full, and the back end sends one output byte per cycle from
// its output register while the receiver is ready. Plain bytes pass at one item per
// cycle; a completed colour code yields ESC plus a six-byte suffix (ESC alone for an
// unknown code), an end-of-message flush up to 3 bytes. A four-entry job queue
// between the input classifier and the byte sequencer absorbs these bursts; the input
// only waits once the queue is full, so the sustained rate is set by the sequencer at
// one output byte per cycle. A byte is queued as a job, then registered for output.
module pipe_color_code_to_ansi (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_s_tlast,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast
);

    pcc_pkg::t_job    push_job;
    pcc_pkg::t_job    head_job;
    pcc_pkg::t_q_stat q_stat;
    logic             push;
    logic             pop;

    pcc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .i_byte   (i_s_tdata),
        .i_eom    (i_s_tlast),
        .i_q_stat (q_stat),
        .o_ready  (o_s_tready),
        .o_push   (push),
        .o_job    (push_job)
    );

    pcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    pcc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (head_job),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_byte   (o_m_tdata),
        .o_last   (o_m_tlast)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_stat.full)
        else $error("job pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("job popped from empty queue");

    a_pop_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> (o_m_tvalid && o_m_tlast))
        else $error("job retired without last byte shown");

    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

endmodule

### design/pcc_front.sv
module pcc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_byte,
    input  logic          i_eom,
    input  pcc_pkg::t_q_stat i_q_stat,
    output logic          o_ready,
    output logic          o_push,
    output pcc_pkg::t_job o_job
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PIPE,
        PH_CODE
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_held, n_held;
    logic        accept;

    function automatic logic [3:0] code_num(input logic [7:0] first, input logic [7:0] second);
        logic [3:0] res;
        res = 4'd0;
        if (first == "0" && second inside {["1":"9"]})
            res = 4'(second - 8'h30);
        else if (first == "1" && second inside {["0":"5"]})
            res = 4'(second - 8'h30) + 4'd10;
        return res;
    endfunction

    assign o_ready = !i_q_stat.full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        o_job      = '0;
        n_phase    = PH_IDLE;
        n_held     = r_held;
        case (r_phase)
            PH_CODE: begin
                o_job.esc = 1'b1;
                o_job.num = code_num(r_held, i_byte);
            end
            PH_PIPE: begin
                n_held  = i_byte;
                n_phase = PH_CODE;
                if (i_byte == pcc_pkg::PIPE_CHAR) begin
                    o_job.lit[0] = pcc_pkg::PIPE_CHAR;
                    o_job.nlit   = 2'd1;
                end
            end
            default: begin
                if (i_byte == pcc_pkg::PIPE_CHAR) begin
                    n_phase = PH_PIPE;
                end else begin
                    o_job.lit[0] = i_byte;
                    o_job.nlit   = 2'd1;
                end
            end
        endcase
        // end of message flushes an unfinished code
        if (i_eom) begin
            if (n_phase == PH_PIPE) begin
                o_job.lit[o_job.nlit] = pcc_pkg::PIPE_CHAR;
                o_job.nlit            = 2'(o_job.nlit + 2'd1);
            end else if (n_phase == PH_CODE) begin
                o_job.lit[o_job.nlit]              = pcc_pkg::PIPE_CHAR;
                o_job.lit[2'(o_job.nlit + 2'd1)]   = n_held;
                o_job.nlit                         = 2'(o_job.nlit + 2'd2);
            end
            n_phase = PH_IDLE;
            n_held  = 8'd0;
        end
    end

    assign o_push = accept && (o_job.esc || o_job.nlit != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= 8'd0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

endmodule

### design/pcc_queue.sv
module pcc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pcc_pkg::t_job    i_job,
    input  logic             i_pop,
    output pcc_pkg::t_job    o_job,
    output pcc_pkg::t_q_stat o_stat
);

    pcc_pkg::t_job                r_mem [pcc_pkg::Q_DEPTH];
    logic [pcc_pkg::Q_AW-1:0]     r_wr, r_rd;
    logic [pcc_pkg::Q_AW:0]       r_cnt;

    assign o_stat.full  = (r_cnt == (pcc_pkg::Q_AW+1)'(pcc_pkg::Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_job        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### design/pcc_back.sv
module pcc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pcc_pkg::t_job    i_job,
    input  pcc_pkg::t_q_stat i_q_stat,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_byte,
    output logic             o_last
);

    logic [2:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       fire;
    logic [2:0] total;
    logic [7:0] sel_byte;
    logic       sel_last;

    // "[i;3cm" suffix, k is the position inside the suffix
    function automatic logic [7:0] suffix_byte(input logic [3:0] num, input logic [2:0] k);
        logic [7:0] colour;
        logic [7:0] res;
        case (num)
            4'd1, 4'd9:   colour = "4";
            4'd2, 4'd10:  colour = "2";
            4'd3, 4'd11:  colour = "6";
            4'd4, 4'd12:  colour = "1";
            4'd5, 4'd13:  colour = "5";
            4'd6, 4'd14:  colour = "3";
            4'd7, 4'd15:  colour = "7";
            default:      colour = "0";
        endcase
        case (k)
            3'd0:    res = "[";
            3'd1:    res = (num >= 4'd8) ? "1" : "0";
            3'd2:    res = ";";
            3'd3:    res = "3";
            3'd4:    res = colour;
            default: res = "m";
        endcase
        return res;
    endfunction

    always_comb begin
        if (i_job.esc) begin
            total = (i_job.num != 4'd0) ? 3'd7 : 3'd1;
            if (r_idx == 3'd0)
                sel_byte = pcc_pkg::ESC_CHAR;
            else
                sel_byte = suffix_byte(i_job.num, 3'(r_idx - 3'd1));
        end else begin
            total    = {1'b0, i_job.nlit};
            sel_byte = i_job.lit[r_idx[1:0]];
        end
    end

    assign sel_last = (r_idx == 3'(total - 3'd1));
    assign fire     = !i_q_stat.empty && (!r_valid || i_ready);
    assign o_pop    = fire && sel_last;
    assign o_valid  = r_valid;
    assign o_byte   = r_byte;
    assign o_last   = r_last;

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_byte <= sel_byte;
            r_last <= sel_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else if (fire) begin
            r_valid <= 1'b1;
            r_idx   <= sel_last ? 3'd0 : 3'(r_idx + 3'd1);
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule

### test/pipe_color_code_to_ansi_tb.sv
`timescale 1ns / 1ps

module pipe_color_code_to_ansi_tb;

    typedef struct {
        logic [7:0] ch;
        logic       eom;
        logic       drain_first;
    } t_text_char;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_ansi_byte;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_OPEN = 2'd1,
        PH_HELD = 2'd2
    } t_pipe_phase;

    localparam int unsigned CALM_TAIL = 60;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata = 8'h00;    // [7:0] in_byte
    logic       s_tlast = 1'b0;
    logic       m_tready = 1'b0;
    logic       o_s_tready;
    logic       o_m_tvalid;
    logic [7:0] o_m_tdata;          // [7:0] out_byte
    logic       o_m_tlast;

    t_text_char  text_chars[$];
    t_ansi_byte  ansi_bytes[$];
    t_pipe_phase pipe_phase = PH_IDLE;
    logic [7:0]  held_char = 8'h00;
    logic        drain_next = 1'b0;
    int          errors = 0;
    int          send_gap = 0;
    int          recv_stall = 0;

    pipe_color_code_to_ansi u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [47:0] colour_suffix(input int unsigned num);
        case (num)
            1:       return "[0;34m";
            2:       return "[0;32m";
            3:       return "[0;36m";
            4:       return "[0;31m";
            5:       return "[0;35m";
            6:       return "[0;33m";
            7:       return "[0;37m";
            8:       return "[1;30m";
            9:       return "[1;34m";
            10:      return "[1;32m";
            11:      return "[1;36m";
            12:      return "[1;31m";
            13:      return "[1;35m";
            14:      return "[1;33m";
            default: return "[1;37m";
        endcase
    endfunction

    // advances the translator state by one text char and queues the bytes it yields
    function automatic void translate_char(input logic [7:0] ch, input logic eom);
        logic [7:0]  outs [0:6];
        int          n;
        int unsigned num;
        logic [47:0] sfx;
        t_ansi_byte  ab;
        n = 0;
        case (pipe_phase)
            PH_HELD: begin
                num = 0;
                if (held_char == "0" && ch >= "1" && ch <= "9")
                    num = 32'(ch - 8'h30);
                else if (held_char == "1" && ch >= "0" && ch <= "5")
                    num = 10 + 32'(ch - 8'h30);
                pipe_phase = PH_IDLE;
                outs[n] = pcc_pkg::ESC_CHAR;
                n++;
                if (num != 0) begin
                    sfx = colour_suffix(num);
                    for (int k = 0; k < 6; k++) begin
                        outs[n] = sfx[47 - 8 * k -: 8];
                        n++;
                    end
                end
            end
            PH_OPEN: begin
                pipe_phase = PH_HELD;
                held_char = ch;
                if (ch == pcc_pkg::PIPE_CHAR) begin
                    outs[n] = pcc_pkg::PIPE_CHAR;
                    n++;
                end
            end
            default: begin
                if (ch == pcc_pkg::PIPE_CHAR) begin
                    pipe_phase = PH_OPEN;
                end else begin
                    pipe_phase = PH_IDLE;
                    outs[n] = ch;
                    n++;
                end
            end
        endcase
        if (eom) begin
            // unfinished code is flushed back as literal text
            if (pipe_phase != PH_IDLE) begin
                outs[n] = pcc_pkg::PIPE_CHAR;
                n++;
                if (pipe_phase == PH_HELD) begin
                    outs[n] = held_char;
                    n++;
                end
            end
            pipe_phase = PH_IDLE;
            held_char = 8'h00;
        end
        for (int k = 0; k < n; k++) begin
            ab.ch = outs[k];
            ab.last = (k == n - 1);
            ansi_bytes.push_back(ab);
        end
    endfunction

    task automatic queue_char(input logic [7:0] ch, input logic eom);
        t_text_char tc;
        tc.ch = ch;
        tc.eom = eom;
        tc.drain_first = drain_next;
        drain_next = 1'b0;
        text_chars.push_back(tc);
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] ch;
        do ch = 8'($urandom_range(0, 255)); while (ch == pcc_pkg::PIPE_CHAR);
        return ch;
    endfunction

    // sender
    always @(posedge i_clk) begin : sender
        t_text_char nxt;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_tready)
                translate_char(s_tdata, s_tlast);
            if (s_tvalid && !o_s_tready) begin
                // hold the item until taken
            end else if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (text_chars.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (text_chars[0].drain_first && ansi_bytes.size() != 0) begin
                s_tvalid <= 1'b0;
            end else if (text_chars.size() > CALM_TAIL && $urandom_range(0, 4) == 0) begin
                send_gap = $urandom_range(0, 7);
                s_tvalid <= 1'b0;
            end else begin
                nxt = text_chars.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= nxt.ch;
                s_tlast <= nxt.eom;
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin : receiver
        t_ansi_byte want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                if (ansi_bytes.size() == 0) begin
                    $display("%0t: unexpected item out_byte=%h last=%b", $time,
                             o_m_tdata, o_m_tlast);
                    errors++;
                end else begin
                    want = ansi_bytes.pop_front();
                    if (o_m_tdata !== want.ch) begin
                        $display("%0t: out_byte expected %h actual %h", $time,
                                 want.ch, o_m_tdata);
                        errors++;
                    end
                    if (o_m_tlast !== want.last) begin
                        $display("%0t: last expected %b actual %b", $time,
                                 want.last, o_m_tlast);
                        errors++;
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else if (text_chars.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
                recv_stall = $urandom_range(0, 7);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("[pipe_color_code_to_ansi] ERROR");
        $finish;
    end

    initial begin
        int          msg_idx;
        int          segs;
        int unsigned num;
        // directed part
        queue_char(8'h00, 1'b0);
        queue_char(8'hFF, 1'b0);
        queue_char("A", 1'b0);
        queue_char(pcc_pkg::PIPE_CHAR, 1'b0);
        queue_char("0", 1'b0);
        queue_char("1", 1'b0);
        queue_char(pcc_pkg::PIPE_CHAR, 1'b0);
        queue_char("1", 1'b0);
        queue_char("5", 1'b0);
        // double pipe, then ESC alone
        queue_char(pcc_pkg::PIPE_CHAR, 1'b0);
        queue_char(pcc_pkg::PIPE_CHAR, 1'b0);
        queue_char("x", 1'b0);
        // background code is unknown
        queue_char(pcc_pkg::PIPE_CHAR, 1'b0);
        queue_char("b", 1'b0);
        queue_char("1", 1'b0);
        queue_char(pcc_pkg::PIPE_CHAR, 1'b0);
        queue_char(8'h00, 1'b0);
        queue_char("7", 1'b0);
        queue_char(pcc_pkg::PIPE_CHAR, 1'b1);
        queue_char(pcc_pkg::PIPE_CHAR, 1'b0);
        queue_char("1", 1'b1);
        queue_char(pcc_pkg::PIPE_CHAR, 1'b0);
        queue_char("0", 1'b0);
        queue_char("9", 1'b1);
        queue_char("z", 1'b1);

        // random messages, mostly well formed
        msg_idx = 0;
        while (text_chars.size() < 410) begin
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 6))
                    queue_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end else begin
                drain_next = (msg_idx == 0) || ($urandom_range(0, 7) == 0);
                msg_idx++;
                segs = $urandom_range(1, 8);
                for (int s = 0; s < segs; s++) begin
                    case ($urandom_range(0, 5))
                        0, 1: queue_char(plain_char(), 1'b0);
                        2, 3: begin
                            num = $urandom_range(1, 15);
                            queue_char(pcc_pkg::PIPE_CHAR, 1'b0);
                            queue_char(num < 10 ? "0" : "1", 1'b0);
                            queue_char(8'(num < 10 ? "0" + num : "0" + num - 10), 1'b0);
                        end
                        4: begin
                            queue_char(pcc_pkg::PIPE_CHAR, 1'b0);
                            queue_char(8'($urandom_range(0, 255)), 1'b0);
                            queue_char(8'($urandom_range(0, 255)), 1'b0);
                        end
                        default: begin
                            queue_char(pcc_pkg::PIPE_CHAR, 1'b0);
                            queue_char(pcc_pkg::PIPE_CHAR, 1'b0);
                            queue_char(plain_char(), 1'b0);
                        end
                    endcase
                end
                case ($urandom_range(0, 3))
                    0: queue_char(pcc_pkg::PIPE_CHAR, 1'b1);
                    1: begin
                        queue_char(pcc_pkg::PIPE_CHAR, 1'b0);
                        queue_char(8'($urandom_range(0, 255)), 1'b1);
                    end
                    default: queue_char(plain_char(), 1'b1);
                endcase
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (text_chars.size() != 0 || s_tvalid) @(posedge i_clk);
        while (ansi_bytes.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("[pipe_color_code_to_ansi] OK");
        else
            $display("[pipe_color_code_to_ansi] ERROR");
        $finish;
    end

endmodule
